[src/rrst_pkg.sv]
// ----------------------------------------------------------------------------
// rrst_pkg
// Shared constants and types of the rounded rectangle strip tessellator.
// ----------------------------------------------------------------------------
package rrst_pkg;

    // default corner radius limit in whole pixels
    localparam int MAX_RADIUS_DEF = 31;
    // default fraction bits of the radius inputs
    localparam int FRAC_BITS_DEF  = 4;

    // fixed field widths
    localparam int COORD_W   = 16;
    localparam int RAD_IN_W  = 13;
    localparam int SPAN_W    = 8;
    localparam int POS_W     = 17;
    localparam int LEN_W     = 15;

    // one strip job as it travels along the pipeline beside the root lanes
    typedef struct packed {
        logic                     mark;   // end of item, carries no strip
        logic signed [COORD_W-1:0] left;
        logic signed [POS_W-1:0]   top;
        logic [LEN_W-1:0]          width;
        logic [LEN_W-1:0]          rows;
    } ctx_t;

endpackage

[src/rrst_if.sv]
// ----------------------------------------------------------------------------
// rrst_if
// Valid/ready channels of the tessellator: rectangle words in, strip words out.
// ----------------------------------------------------------------------------
interface rrst_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rrst_pkg::COORD_W-1:0]   rect_left;
    logic signed [rrst_pkg::COORD_W-1:0]   rect_top;
    logic signed [rrst_pkg::COORD_W-1:0]   rect_width;
    logic signed [rrst_pkg::COORD_W-1:0]   rect_height;
    logic signed [rrst_pkg::RAD_IN_W-1:0]  radius_top_left;
    logic signed [rrst_pkg::RAD_IN_W-1:0]  radius_top_right;
    logic signed [rrst_pkg::RAD_IN_W-1:0]  radius_bottom_right;
    logic signed [rrst_pkg::RAD_IN_W-1:0]  radius_bottom_left;
    logic [rrst_pkg::SPAN_W-1:0]           strip_height;

    modport source (
        output valid, rect_left, rect_top, rect_width, rect_height,
               radius_top_left, radius_top_right, radius_bottom_right,
               radius_bottom_left, strip_height,
        input  ready
    );
    modport sink (
        input  valid, rect_left, rect_top, rect_width, rect_height,
               radius_top_left, radius_top_right, radius_bottom_right,
               radius_bottom_left, strip_height,
        output ready
    );
endinterface

interface rrst_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rrst_pkg::POS_W-1:0]  strip_left;
    logic signed [rrst_pkg::POS_W-1:0]  strip_top;
    logic [rrst_pkg::LEN_W-1:0]         strip_width;
    logic [rrst_pkg::LEN_W-1:0]         strip_rows;
    logic                               last_strip;

    modport source (
        output valid, strip_left, strip_top, strip_width, strip_rows, last_strip,
        input  ready
    );
    modport sink (
        input  valid, strip_left, strip_top, strip_width, strip_rows, last_strip,
        output ready
    );
endinterface

[src/rounded_rect_strip_tessellator_unit.sv]
// ----------------------------------------------------------------------------
// rounded_rect_strip_tessellator_unit
// Covers a rounded rectangle from the inside with horizontal strips.
// ----------------------------------------------------------------------------
// One rectangle word is taken at a time. It passes the setup states (accept,
// radius clamp, band sizing), then issues one strip job per cycle while the
// output does not stall: the top band strips, the middle band when it has
// height, the bottom band strips and one end mark; a rectangle of no width or
// height issues none of these. The next word is accepted only after the end
// mark. Each job passes two corner lanes, each a square root pipeline with one
// result bit per stage. The last strip of a rectangle waits for its end mark.
// A stalled output holds the whole pipeline and the issue sequencer.
module rounded_rect_strip_tessellator_unit #(
    parameter int MAX_RADIUS = rrst_pkg::MAX_RADIUS_DEF,
    parameter int FRAC_BITS  = rrst_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rrst_in_if.sink     rect_in,
    rrst_out_if.source  strip_out
);

    localparam int IFRAC = FRAC_BITS + 1;
    localparam int PXW   = $clog2(MAX_RADIUS + 1);
    localparam int RW    = PXW + IFRAC;
    localparam int LAT   = RW + 4;

    logic adv;
    logic job_valid;
    rrst_pkg::ctx_t job_ctx;
    logic [RW-1:0] job_rl, job_rr;
    logic [PXW-1:0] job_d;
    logic [PXW-1:0] li, ri;

    logic           vline_reg [LAT];
    rrst_pkg::ctx_t cline_reg [LAT];

    rrst_seq #(
        .MAX_RADIUS (MAX_RADIUS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .rect_in   (rect_in),
        .adv       (adv),
        .job_valid (job_valid),
        .job_ctx   (job_ctx),
        .job_rl    (job_rl),
        .job_rr    (job_rr),
        .job_d     (job_d)
    );

    rrst_inset #(
        .MAX_RADIUS (MAX_RADIUS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_inset_left (
        .clk   (clk),
        .adv   (adv),
        .r     (job_rl),
        .d     (job_d),
        .inset (li)
    );

    rrst_inset #(
        .MAX_RADIUS (MAX_RADIUS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_inset_right (
        .clk   (clk),
        .adv   (adv),
        .r     (job_rr),
        .d     (job_d),
        .inset (ri)
    );

    // job valid bits beside the corner lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vline_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vline_reg[0] <= job_valid;
            for (int i = 1; i < LAT; i++)
                vline_reg[i] <= vline_reg[i-1];
        end
    end

    // job context beside the corner lanes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cline_reg[0] <= job_ctx;
            for (int i = 1; i < LAT; i++)
                cline_reg[i] <= cline_reg[i-1];
        end
    end

    rrst_emit #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (vline_reg[LAT-1]),
        .cand_ctx   (cline_reg[LAT-1]),
        .li         (li),
        .ri         (ri),
        .adv        (adv),
        .strip_out  (strip_out)
    );

endmodule

[src/rrst_seq.sv]
// ----------------------------------------------------------------------------
// rrst_seq
// Takes one rectangle word, clamps the radii, sizes the bands and, while adv is
// high, issues one strip job per cycle, then an end mark; empty ones get none.
// ----------------------------------------------------------------------------
module rrst_seq #(
    parameter int MAX_RADIUS = rrst_pkg::MAX_RADIUS_DEF,
    parameter int FRAC_BITS  = rrst_pkg::FRAC_BITS_DEF,
    localparam int IFRAC = FRAC_BITS + 1,
    localparam int PXW   = $clog2(MAX_RADIUS + 1),
    localparam int RW    = PXW + IFRAC
) (
    input  logic              clk,
    input  logic              rst_n,
    rrst_in_if.sink           rect_in,
    input  logic              adv,
    output logic              job_valid,
    output rrst_pkg::ctx_t    job_ctx,
    output logic [RW-1:0]     job_rl,
    output logic [RW-1:0]     job_rr,
    output logic [PXW-1:0]    job_d
);

    localparam int HW = rrst_pkg::COORD_W + FRAC_BITS;
    localparam int EW = PXW + rrst_pkg::SPAN_W + 1;
    localparam logic [HW-1:0] RMAX = HW'(MAX_RADIUS * (2 ** IFRAC));
    localparam logic [RW:0]   CEIL_ADD = (RW+1)'(2 ** IFRAC - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLAMP = 7'b0000010,
        S_BAND  = 7'b0000100,
        S_TOP   = 7'b0001000,
        S_MID   = 7'b0010000,
        S_BOT   = 7'b0100000,
        S_MARK  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [PXW-1:0] row_reg, row_next;
    logic job_valid_reg, job_valid_next;

    logic signed [15:0] x_reg, y_reg, w_reg, h_reg;
    logic signed [12:0] rtl_raw_reg, rtr_raw_reg, rbr_raw_reg, rbl_raw_reg;
    logic [7:0] sp_raw_reg, sp_reg;
    logic [RW-1:0] tl_reg, tr_reg, br_reg, bl_reg;
    logic [PXW-1:0] top_reg, bot_reg;
    rrst_pkg::ctx_t ctx_reg;
    logic [RW-1:0] rl_reg, rr_reg;
    logic [PXW-1:0] d_reg;

    logic empty;
    logic [HW-1:0] half;
    logic [PXW-1:0] top_c, bot_c, rem;
    logic fin;
    logic [7:0] rh;
    logic signed [16:0] mid_h;
    logic issue;
    rrst_pkg::ctx_t iss_ctx;
    logic [RW-1:0] iss_rl, iss_rr;
    logic [PXW-1:0] iss_d;

    // radius to internal fixed point, clamped to zero, half side and limit
    function automatic logic [RW-1:0] clamp_rad(logic signed [12:0] raw,
                                                 logic [HW-1:0] lim);
        logic signed [HW:0] r;
        logic [HW-1:0] u;
        r = {{(HW - 12){raw[12]}}, raw} <<< 1;
        u = r[HW] ? '0 : r[HW-1:0];
        if (u > lim)
            u = lim;
        if (u > RMAX)
            u = RMAX;
        return u[RW-1:0];
    endfunction

    // radius to whole pixels, rounded up
    function automatic logic [PXW-1:0] ceil_px(logic [RW-1:0] a, logic [RW-1:0] b);
        logic [RW:0] m;
        m = (a > b) ? {1'b0, a} : {1'b0, b};
        m = (m + CEIL_ADD) >> IFRAC;
        return m[PXW-1:0];
    endfunction

    assign rect_in.ready = (state_reg == S_IDLE);
    assign job_valid = job_valid_reg;
    assign job_ctx   = ctx_reg;
    assign job_rl    = rl_reg;
    assign job_rr    = rr_reg;
    assign job_d     = d_reg;

    // band setup terms
    assign empty = (w_reg <= 16'sd0) || (h_reg <= 16'sd0);
    assign half  = (w_reg < h_reg) ? (HW'(w_reg[14:0]) << FRAC_BITS)
                                   : (HW'(h_reg[14:0]) << FRAC_BITS);
    assign top_c = ceil_px(tl_reg, tr_reg);
    assign bot_c = ceil_px(bl_reg, br_reg);
    assign mid_h = 17'(h_reg) - 17'(top_reg) - 17'(bot_reg);

    // rows left in the current band and this strip's height
    assign rem = (state_reg == S_BOT) ? (bot_reg - row_reg) : (top_reg - row_reg);
    assign fin = (EW'(rem) <= EW'(sp_reg));
    assign rh  = fin ? 8'(rem) : sp_reg;

    // band walk
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        issue      = 1'b0;
        iss_ctx    = '0;
        iss_rl     = '0;
        iss_rr     = '0;
        iss_d      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rect_in.valid)
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                state_next = empty ? S_IDLE : S_BAND;
            end
            S_BAND:
            begin
                row_next   = '0;
                state_next = (top_c != '0) ? S_TOP : S_MID;
            end
            S_TOP:
            begin
                iss_ctx.left  = x_reg;
                iss_ctx.top   = 17'(y_reg) + 17'(row_reg);
                iss_ctx.width = w_reg[14:0];
                iss_ctx.rows  = 15'(rh);
                iss_rl        = tl_reg;
                iss_rr        = tr_reg;
                iss_d         = PXW'(EW'(row_reg) + EW'(rh));
                if (adv)
                begin
                    issue = 1'b1;
                    if (fin)
                    begin
                        state_next = S_MID;
                        row_next   = '0;
                    end
                    else
                        row_next = PXW'(EW'(row_reg) + EW'(sp_reg));
                end
            end
            S_MID:
            begin
                iss_ctx.left  = x_reg;
                iss_ctx.top   = 17'(y_reg) + 17'(top_reg);
                iss_ctx.width = w_reg[14:0];
                iss_ctx.rows  = mid_h[14:0];
                if (mid_h <= 17'sd0 || adv)
                begin
                    issue      = (mid_h > 17'sd0);
                    row_next   = '0;
                    state_next = (bot_reg != '0) ? S_BOT : S_MARK;
                end
            end
            S_BOT:
            begin
                iss_ctx.left  = x_reg;
                iss_ctx.top   = 17'(y_reg) + 17'(h_reg) - 17'(bot_reg) + 17'(row_reg);
                iss_ctx.width = w_reg[14:0];
                iss_ctx.rows  = 15'(rh);
                iss_rl        = bl_reg;
                iss_rr        = br_reg;
                iss_d         = rem;
                if (adv)
                begin
                    issue = 1'b1;
                    if (fin)
                    begin
                        state_next = S_MARK;
                        row_next   = '0;
                    end
                    else
                        row_next = PXW'(EW'(row_reg) + EW'(sp_reg));
                end
            end
            S_MARK:
            begin
                iss_ctx.mark = 1'b1;
                if (adv)
                begin
                    issue      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign job_valid_next = adv ? issue : job_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            job_valid_reg <= job_valid_next;
        end
    end

    // item and job payload
    always_ff @(posedge clk)
    begin
        if (rect_in.valid && rect_in.ready)
        begin
            x_reg       <= rect_in.rect_left;
            y_reg       <= rect_in.rect_top;
            w_reg       <= rect_in.rect_width;
            h_reg       <= rect_in.rect_height;
            rtl_raw_reg <= rect_in.radius_top_left;
            rtr_raw_reg <= rect_in.radius_top_right;
            rbr_raw_reg <= rect_in.radius_bottom_right;
            rbl_raw_reg <= rect_in.radius_bottom_left;
            sp_raw_reg  <= rect_in.strip_height;
        end
        if (state_reg == S_CLAMP)
        begin
            tl_reg <= clamp_rad(rtl_raw_reg, half);
            tr_reg <= clamp_rad(rtr_raw_reg, half);
            br_reg <= clamp_rad(rbr_raw_reg, half);
            bl_reg <= clamp_rad(rbl_raw_reg, half);
            sp_reg <= (sp_raw_reg == 8'd0) ? 8'd1 : sp_raw_reg;
        end
        if (state_reg == S_BAND)
        begin
            top_reg <= top_c;
            bot_reg <= bot_c;
        end
        if (adv && issue)
        begin
            ctx_reg <= iss_ctx;
            rl_reg  <= iss_rl;
            rr_reg  <= iss_rr;
            d_reg   <= iss_d;
        end
    end

endmodule

[src/rrst_inset.sv]
// ----------------------------------------------------------------------------
// rrst_inset
// One corner lane: r - sqrt(r^2 - (r-d)^2) rounded up to pixels, with the
// square root spread over one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module rrst_inset #(
    parameter int MAX_RADIUS = rrst_pkg::MAX_RADIUS_DEF,
    parameter int FRAC_BITS  = rrst_pkg::FRAC_BITS_DEF,
    localparam int IFRAC = FRAC_BITS + 1,
    localparam int PXW   = $clog2(MAX_RADIUS + 1),
    localparam int RW    = PXW + IFRAC
) (
    input  logic            clk,
    input  logic            adv,
    input  logic [RW-1:0]   r,
    input  logic [PXW-1:0]  d,
    output logic [PXW-1:0]  inset
);

    localparam int SW = 2 * RW;
    localparam logic [RW:0] CEIL_ADD = (RW+1)'(2 ** IFRAC - 1);

    logic [RW-1:0] r1_reg, dy1_reg, r2_reg;
    logic          z1_reg, z2_reg;
    logic [SW-1:0] rr2_reg, dd2_reg;

    logic [SW-1:0] s_reg   [RW+1];
    logic [SW-1:0] res_reg [RW+1];
    logic [RW-1:0] r_reg   [RW+1];
    logic          z_reg   [RW+1];

    logic [RW-1:0] dpx;
    logic [RW:0]   diff, up;
    logic [PXW-1:0] inset_reg;

    assign dpx = RW'(d) << IFRAC;

    // distance from center and the two squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg     <= r;
            z1_reg     <= (r == '0) || (dpx >= r);
            dy1_reg    <= r - dpx;
            r2_reg     <= r1_reg;
            z2_reg     <= z1_reg;
            rr2_reg    <= SW'(r1_reg) * SW'(r1_reg);
            dd2_reg    <= SW'(dy1_reg) * SW'(dy1_reg);
            s_reg[0]   <= rr2_reg - dd2_reg;
            res_reg[0] <= '0;
            r_reg[0]   <= r2_reg;
            z_reg[0]   <= z2_reg;
        end
    end

    // restoring square root, one result bit per stage
    for (genvar k = 0; k < RW; k++)
    begin : g_root
        localparam logic [SW-1:0] RBIT = SW'(1) << (2 * (RW - 1 - k));
        logic [SW-1:0] trial, s_next, res_next;

        assign trial = res_reg[k] + RBIT;

        always_comb
        begin
            if (s_reg[k] >= trial)
            begin
                s_next   = s_reg[k] - trial;
                res_next = (res_reg[k] >> 1) + RBIT;
            end
            else
            begin
                s_next   = s_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_reg[k+1]   <= s_next;
                res_reg[k+1] <= res_next;
                r_reg[k+1]   <= r_reg[k];
                z_reg[k+1]   <= z_reg[k];
            end
        end
    end

    // pixel inset, rounded up
    assign diff = {1'b0, r_reg[RW]} - {1'b0, res_reg[RW][RW-1:0]};
    assign up   = (diff + CEIL_ADD) >> IFRAC;

    always_ff @(posedge clk)
    begin
        if (adv)
            inset_reg <= z_reg[RW] ? '0 : up[PXW-1:0];
    end

    assign inset = inset_reg;

endmodule

[src/rrst_emit.sv]
// ----------------------------------------------------------------------------
// rrst_emit
// Drops strips of no width, holds the newest strip back until the next one or
// the end mark shows whether it is the last, and drives the output register.
// ----------------------------------------------------------------------------
module rrst_emit #(
    parameter int MAX_RADIUS = rrst_pkg::MAX_RADIUS_DEF,
    localparam int PXW = $clog2(MAX_RADIUS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cand_valid,
    input  rrst_pkg::ctx_t  cand_ctx,
    input  logic [PXW-1:0]  li,
    input  logic [PXW-1:0]  ri,
    output logic            adv,
    rrst_out_if.source      strip_out
);

    logic held_valid_reg, held_valid_next;
    logic out_valid_reg, out_valid_next;
    logic signed [16:0] held_left_reg, held_top_reg;
    logic [14:0] held_width_reg, held_rows_reg;
    logic signed [16:0] out_left_reg, out_top_reg;
    logic [14:0] out_width_reg, out_rows_reg;
    logic out_last_reg;

    logic signed [16:0] rw;
    logic keep, is_mark, push;

    // strip width after both insets
    assign rw      = 17'(cand_ctx.width) - 17'(li) - 17'(ri);
    assign is_mark = cand_valid && cand_ctx.mark;
    assign keep    = cand_valid && !cand_ctx.mark && (rw > 17'sd0);
    assign push    = held_valid_reg && (keep || is_mark);

    assign adv = !out_valid_reg || strip_out.ready;

    // hold and output valid bits
    always_comb
    begin
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg;
        if (adv)
        begin
            out_valid_next = push;
            if (keep)
                held_valid_next = 1'b1;
            else if (is_mark)
                held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // held strip and output word
    always_ff @(posedge clk)
    begin
        if (adv && push)
        begin
            out_left_reg  <= held_left_reg;
            out_top_reg   <= held_top_reg;
            out_width_reg <= held_width_reg;
            out_rows_reg  <= held_rows_reg;
            out_last_reg  <= is_mark;
        end
        if (adv && keep)
        begin
            held_left_reg  <= 17'(cand_ctx.left) + 17'(li);
            held_top_reg   <= cand_ctx.top;
            held_width_reg <= rw[14:0];
            held_rows_reg  <= cand_ctx.rows;
        end
    end

    assign strip_out.valid       = out_valid_reg;
    assign strip_out.strip_left  = out_left_reg;
    assign strip_out.strip_top   = out_top_reg;
    assign strip_out.strip_width = out_width_reg;
    assign strip_out.strip_rows  = out_rows_reg;
    assign strip_out.last_strip  = out_last_reg;

endmodule

[src/rrst_check.sv]
// ----------------------------------------------------------------------------
// rrst_check
// Port level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module rrst_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] strip_left,
    input logic [16:0] strip_top,
    input logic [14:0] strip_width,
    input logic [14:0] strip_rows,
    input logic        last_strip
);

    // a stalled word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("strip word dropped while stalled");

    // a stalled word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(strip_left) && $stable(strip_top)
            && $stable(strip_width) && $stable(strip_rows) && $stable(last_strip))
        else $error("strip word changed while stalled");

    // only strips with area leave
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> strip_width != 15'd0 && strip_rows != 15'd0)
        else $error("empty strip emitted");

    // one rectangle at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("rectangle word taken during setup");

endmodule

bind rounded_rect_strip_tessellator_unit rrst_check u_rrst_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (rect_in.valid),
    .in_ready    (rect_in.ready),
    .out_valid   (strip_out.valid),
    .out_ready   (strip_out.ready),
    .strip_left  (strip_out.strip_left),
    .strip_top   (strip_out.strip_top),
    .strip_width (strip_out.strip_width),
    .strip_rows  (strip_out.strip_rows),
    .last_strip  (strip_out.last_strip)
);
